### rtl/gae_pkg.sv
package gae_pkg;

    // Sizing
    localparam int MAX_NODES       = 4096;
    localparam int EXP_TABLE_DEPTH = 256;   // power of two, 16..4096
    localparam int TAB_BITS        = $clog2(EXP_TABLE_DEPTH);
    localparam int QUEUE_DEPTH     = 4;     // power of two
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

    // Field widths
    localparam int NODE_W  = 12;
    localparam int DIST_W  = 16;
    localparam int IVAR_W  = 24;
    localparam int AFF_W   = 16;
    localparam int D2_W    = 2 * DIST_W;        // Q20.12
    localparam int X_W     = D2_W + IVAR_W;     // Q20.36
    localparam int FRAC_W  = 16;
    localparam int TAB_W   = 31;                // Q1.30, max value 1.0
    localparam int IN_W    = 2 * NODE_W + DIST_W;
    localparam int OUT_W   = 2 * NODE_W + AFF_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = IVAR_W;

    // Interpolation bit positions inside x: index ends just below bit 40, scaled by depth/16
    localparam int IDX_LSB  = 40 - TAB_BITS;
    localparam int FRAC_LSB = 24 - TAB_BITS;

    localparam logic [DIST_W-1:0] MAX_DISTANCE_RST = 16'd3200;
    localparam logic [IVAR_W-1:0] INV_VARIANCE_RST = 24'd4660;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_DISTANCE = 2'd0,
        REG_INV_VARIANCE = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [DIST_W-1:0] max_distance;
        logic [IVAR_W-1:0] inv_variance;
    } cfg_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic [NODE_W-1:0] col;
        logic [NODE_W-1:0] row;
    } item_t;

    typedef logic [TAB_W-1:0] exp_row_t [EXP_TABLE_DEPTH];

    // exp(-x) samples over [0,16), step 16/depth. Entry i holds T[i + shift].
    function automatic exp_row_t build_exp_tab(input int shift);
        exp_row_t    tab;
        logic [63:0] h;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] e;
        logic [63:0] t;
        h    = (64'd16 << 30) / EXP_TABLE_DEPTH;
        term = 64'd1 << 30;
        pos  = 64'd1 << 30;
        neg  = 64'd0;
        for (int k = 1; k <= 24; k++)
        begin
            term = ((term * h) >> 30) / 64'(k);
            if (k % 2 == 1)
                neg = neg + term;
            else
                pos = pos + term;
        end
        e = (pos > neg) ? pos - neg : 64'd0;
        if (e > (64'd1 << 30))
            e = 64'd1 << 30;
        t = 64'd1 << 30;
        for (int i = 0; i <= EXP_TABLE_DEPTH; i++)
        begin
            if (i >= shift && i - shift < EXP_TABLE_DEPTH)
                tab[i - shift] = t[TAB_W-1:0];
            t = (t * e + (64'd1 << 29)) >> 30;
        end
        return tab;
    endfunction

    localparam exp_row_t EXP_TAB_LO = build_exp_tab(0);
    localparam exp_row_t EXP_TAB_HI = build_exp_tab(1);

endpackage

### rtl/gae_front.sv
// Cell classifier: keeps strictly-lower-triangle cells within the distance limit.
module gae_front (
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [gae_pkg::IN_W-1:0]          s_tdata,
    input  logic [gae_pkg::DIST_W-1:0]        max_distance,
    input  logic                              q_full,
    output logic                              q_push,
    output gae_pkg::item_t                    q_item
);

    gae_pkg::item_t item;
    logic           keep;

    assign item = gae_pkg::item_t'(s_tdata);

    always_comb
    begin
        keep = 1'b1;
        if (32'(item.row) >= 32'(gae_pkg::MAX_NODES) || 32'(item.col) >= 32'(gae_pkg::MAX_NODES))
            keep = 1'b0;
        if (item.row <= item.col)
            keep = 1'b0;
        if (item.distance > max_distance)
            keep = 1'b0;
    end

    // dropped cells are consumed at once; kept ones need queue room
    assign s_tready = !q_full || !keep;
    assign q_push   = s_tvalid && !q_full && keep;
    assign q_item   = item;

endmodule

### rtl/gae_queue.sv
// Small FIFO between classifier and affinity pipeline.
module gae_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  gae_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output gae_pkg::item_t pop_item,
    output logic           empty
);

    gae_pkg::item_t                  mem [gae_pkg::QUEUE_DEPTH];
    logic [gae_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [gae_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [gae_pkg::QCNT_W-1:0]      count_reg,  count_next;

    assign full     = (count_reg == gae_pkg::QCNT_W'(gae_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = wr_ptr_reg + gae_pkg::QPTR_W'(1);
        if (pop)
            rd_ptr_next = rd_ptr_reg + gae_pkg::QPTR_W'(1);
        if (push && !pop)
            count_next = count_reg + gae_pkg::QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - gae_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

endmodule

### rtl/gae_back.sv
// Affinity pipeline and edge-pair emitter.
// d*d -> x = d2*ivar -> table lookup -> slope*frac -> round/saturate -> two beats.
module gae_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [gae_pkg::IVAR_W-1:0]    inv_variance,
    input  logic                          q_empty,
    input  gae_pkg::item_t                q_item,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [gae_pkg::OUT_W-1:0]     m_tdata,
    output logic                          m_tlast
);

    logic adv;

    // stage 1: square
    logic                          s1_valid_reg;
    logic [gae_pkg::NODE_W-1:0]    s1_row_reg, s1_col_reg;
    logic [gae_pkg::D2_W-1:0]      s1_d2_reg;
    // stage 2: scale by 1/variance
    logic                          s2_valid_reg;
    logic [gae_pkg::NODE_W-1:0]    s2_row_reg, s2_col_reg;
    logic [gae_pkg::X_W-1:0]       s2_x_reg;
    // stage 3: table lookup
    logic                          s3_valid_reg;
    logic [gae_pkg::NODE_W-1:0]    s3_row_reg, s3_col_reg;
    logic [gae_pkg::TAB_W-1:0]     s3_a_reg, s3_b_reg;
    logic [gae_pkg::FRAC_W-1:0]    s3_f_reg;
    logic                          s3_zero_reg;
    // stage 4: interpolation product
    logic                          s4_valid_reg;
    logic [gae_pkg::NODE_W-1:0]    s4_row_reg, s4_col_reg;
    logic [gae_pkg::TAB_W-1:0]     s4_a_reg;
    logic [gae_pkg::TAB_W-1:0]     s4_prod_reg;
    logic                          s4_zero_reg;
    // output pair register
    logic                          out_valid_reg;
    logic                          beat_reg;
    logic [gae_pkg::NODE_W-1:0]    out_row_reg, out_col_reg;
    logic [gae_pkg::AFF_W-1:0]     out_aff_reg;

    logic                          x_over;
    logic [gae_pkg::TAB_BITS-1:0]  idx;
    logic [gae_pkg::TAB_W-1:0]     diff;
    logic [gae_pkg::TAB_W+gae_pkg::FRAC_W-1:0] prod;
    logic [gae_pkg::TAB_W-1:0]     v;
    logic [gae_pkg::TAB_W:0]       r_full;
    logic [gae_pkg::AFF_W-1:0]     aff;

    // whole pipe moves when the pair register is free or its second beat leaves
    assign adv   = !out_valid_reg || (m_tready && beat_reg);
    assign q_pop = adv && !q_empty;

    assign x_over = (s2_x_reg[gae_pkg::X_W-1:40] != '0);
    assign idx    = s2_x_reg[gae_pkg::IDX_LSB +: gae_pkg::TAB_BITS];

    assign diff = (s3_a_reg > s3_b_reg) ? s3_a_reg - s3_b_reg : '0;
    assign prod = 47'(diff) * 47'(s3_f_reg);

    always_comb
    begin
        v      = s4_a_reg - s4_prod_reg;
        r_full = ({1'b0, v} + 32'(1 << 13)) >> 14;
        if (s4_zero_reg)
            aff = '0;
        else if (r_full > 32'(16'hFFFF))
            aff = 16'hFFFF;
        else
            aff = r_full[gae_pkg::AFF_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            beat_reg      <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= q_pop;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            out_valid_reg <= s4_valid_reg;
            beat_reg      <= 1'b0;
        end
        else if (m_tready)
        begin
            beat_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_row_reg  <= q_item.row;
            s1_col_reg  <= q_item.col;
            s1_d2_reg   <= 32'(q_item.distance) * 32'(q_item.distance);

            s2_row_reg  <= s1_row_reg;
            s2_col_reg  <= s1_col_reg;
            s2_x_reg    <= 56'(s1_d2_reg) * 56'(inv_variance);

            s3_row_reg  <= s2_row_reg;
            s3_col_reg  <= s2_col_reg;
            s3_a_reg    <= gae_pkg::EXP_TAB_LO[idx];
            s3_b_reg    <= gae_pkg::EXP_TAB_HI[idx];
            s3_f_reg    <= s2_x_reg[gae_pkg::FRAC_LSB +: gae_pkg::FRAC_W];
            s3_zero_reg <= x_over;

            s4_row_reg  <= s3_row_reg;
            s4_col_reg  <= s3_col_reg;
            s4_a_reg    <= s3_a_reg;
            s4_prod_reg <= prod[gae_pkg::FRAC_W +: gae_pkg::TAB_W];
            s4_zero_reg <= s3_zero_reg;

            out_row_reg <= s4_row_reg;
            out_col_reg <= s4_col_reg;
            out_aff_reg <= aff;
        end
    end

    // first beat (col,row), second beat (row,col) with tlast
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = beat_reg;
    assign m_tdata  = beat_reg ? {out_aff_reg, out_col_reg, out_row_reg}
                               : {out_aff_reg, out_row_reg, out_col_reg};

endmodule

### rtl/gaussian_affinity_edge_emitter_core.sv
// Gaussian affinity edge emitter. Takes one distance-matrix cell per input beat
// (row, column, Q10.6 distance) and, for cells strictly below the diagonal whose
// distance is within max_distance, emits edge beats: first (col,row,aff), then
// (row,col,aff) with tlast. aff = exp(-d*d*inv_variance) in Q0.16 from a
// 256-step table with linear interpolation; 65535 means 1.0, and exponents of
// 16 or more give 0. Cells that emit nothing are taken one per cycle. Kept
// cells go through a 4-entry queue into a 4-stage pipeline feeding a pair
// register; the single result channel, which carries both beats of each kept cell,
// sets the sustained rate. After its pop, a cell passes through stages s1 to
// s4 into the pair register, which then presents the cell's first beat.
// Config writes (index 0: max_distance, 1: inv_variance, others ignored) are
// meant for idle periods only.
module gaussian_affinity_edge_emitter_core (
    input  logic                             clk,
    input  logic                             rst_n,
    // cell stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [gae_pkg::IN_W-1:0]         s_tdata,   // row_index, col_index, distance
    // edge stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [gae_pkg::OUT_W-1:0]        m_tdata,   // source_node, dest_node, affinity
    output logic                             m_tlast,   // last_edge
    // register writes
    input  logic                             cfg_we,
    input  logic [gae_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gae_pkg::CFG_DATA_W-1:0]   cfg_data
);

    gae_pkg::cfg_t   cfg_reg, cfg_next;
    logic            q_full, q_empty, q_push, q_pop;
    gae_pkg::item_t  push_item, pop_item;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (gae_pkg::cfg_reg_t'(cfg_index))
                gae_pkg::REG_MAX_DISTANCE: cfg_next.max_distance = cfg_data[gae_pkg::DIST_W-1:0];
                gae_pkg::REG_INV_VARIANCE: cfg_next.inv_variance = cfg_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_distance <= gae_pkg::MAX_DISTANCE_RST;
            cfg_reg.inv_variance <= gae_pkg::INV_VARIANCE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    gae_front u_front (
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .max_distance (cfg_reg.max_distance),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_item       (push_item)
    );

    gae_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .empty     (q_empty)
    );

    gae_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .inv_variance (cfg_reg.inv_variance),
        .q_empty      (q_empty),
        .q_item       (pop_item),
        .q_pop        (q_pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast)
    );

endmodule
